>>> design/spvc_pkg.sv
// Shared constants, codes and types for the seat pressure valve controller.
package spvc_pkg;

    // Button bank size and index width
    localparam int BUTTON_COUNT = 8;
    localparam int BTN_IDX_W    = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;
    localparam int BTN_FIELD_W  = 3;
    localparam int LEVEL_PAD_W  = 16;
    localparam int REPORT_W     = 8;

    // Seat occupancy sensors
    localparam int SEAT_A = 5;
    localparam int SEAT_B = 6;
    localparam int SEAT_C = 7;

    // Field widths
    localparam int TIME_W     = 32;
    localparam int SETPOINT_W = 8;
    localparam int TOL_W      = 4;
    localparam int DEB_W      = 10;
    localparam int PSI_W      = 11;
    localparam int PSI_EXT_W  = 13;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_FRONT_LIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRONT_HEAVY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REAR_LIGHT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REAR_HEAVY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE    = 3'd5;

    // Reset values
    localparam logic [SETPOINT_W-1:0] RST_LIGHT_SP = 8'd28;
    localparam logic [SETPOINT_W-1:0] RST_HEAVY_SP = 8'd35;
    localparam logic [TOL_W-1:0]      RST_TOL      = 4'd1;
    localparam logic [DEB_W-1:0]      RST_DEBOUNCE = 10'd50;

    // Vent threshold above the front target
    localparam logic signed [PSI_EXT_W-1:0] VENT_MARGIN = 13'sd1;

    // Operation codes
    localparam logic OP_BUTTON   = 1'b0;
    localparam logic OP_PRESSURE = 1'b1;

    // Drive levels
    typedef struct packed {
        logic vent;
        logic fill;
        logic comp;
    } t_drive;

    localparam t_drive DRIVE_OFF  = '{vent: 1'b0, fill: 1'b0, comp: 1'b0};
    localparam t_drive DRIVE_FILL = '{vent: 1'b0, fill: 1'b1, comp: 1'b1};
    localparam t_drive DRIVE_VENT = '{vent: 1'b1, fill: 1'b0, comp: 1'b0};

    // Button event handed to the debounce unit
    typedef struct packed {
        logic                   en;
        logic [BTN_FIELD_W-1:0] idx;
        logic                   level;
        logic [TIME_W-1:0]      stamp;
    } t_btn_evt;

    // Target latch request from the debounce unit
    typedef struct packed {
        logic latch;
        logic heavy;
    } t_seat_upd;

endpackage

>>> design/seat_pressure_valve_controller_core.sv
// Top level of the seat pressure valve controller: handshake, config, targets, drives.
//
// Input channel (i_valid / o_stall) takes one transaction per cycle unless o_stall is
// high: either a button event (i_op = 0: index, pressed level, ms timestamp) or a
// pressure sample (i_op = 1: signed PSI). Every transaction yields exactly one result
// transaction on the output channel (o_valid / i_stall) carrying the drive
// levels, the latched front and rear targets and the debounced button levels.
// The item is captured in the input register, then processed in one pass that
// updates state and loads the result register. Throughput is one transaction per
// cycle while the receiver does not stall, as the debounce compare and pressure
// compares all fit in that single pass.
// When the receiver stalls, the result holds, the input register fills, and
// o_stall rises only once both registers are occupied.
// Configuration writes (i_cfg_we, i_cfg_idx, i_cfg_wdata) take effect at once;
// the user must make them while the block is idle; the block does not enforce
// it. Setpoint writes reach the latched targets at the next accepted seat event.
// Reset empties both registers and restores register defaults, released levels,
// zero timestamps, light targets and all drives off.
module seat_pressure_valve_controller_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_op,
    input  logic [2:0]                          i_button_index,
    input  logic                                i_button_pressed,
    input  logic [31:0]                         i_time_ms,
    input  logic signed [10:0]                  i_pressure_psi,
    // output channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic                                o_compressor_on,
    output logic                                o_fill_valve_on,
    output logic                                o_vent_valve_on,
    output logic [7:0]                          o_front_setpoint,
    output logic [7:0]                          o_rear_setpoint,
    output logic [7:0]                          o_stable_buttons,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [spvc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [spvc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);
    import spvc_pkg::*;

    // Configuration registers
    logic [SETPOINT_W-1:0] r_front_light;
    logic [SETPOINT_W-1:0] r_front_heavy;
    logic [SETPOINT_W-1:0] r_rear_light;
    logic [SETPOINT_W-1:0] r_rear_heavy;
    logic [TOL_W-1:0]      r_tol;
    logic [DEB_W-1:0]      r_debounce;

    // Input register
    logic                   r_in_valid;
    logic                   r_op;
    logic [BTN_FIELD_W-1:0] r_idx;
    logic                   r_pressed;
    logic [TIME_W-1:0]      r_time;
    logic [PSI_W-1:0]       r_psi;

    // Result register (also the block state)
    logic                   r_out_valid;
    t_drive                 r_drive;
    t_drive                 n_drive;
    logic [SETPOINT_W-1:0]  r_front;
    logic [SETPOINT_W-1:0]  r_rear;

    logic                    advance;
    logic                    take_in;
    logic                    process;
    t_btn_evt                evt;
    t_seat_upd               seat;
    logic [BUTTON_COUNT-1:0] levels;

    logic signed [PSI_EXT_W-1:0] p_ext;
    logic signed [PSI_EXT_W-1:0] sp_ext;
    logic signed [PSI_EXT_W-1:0] tol_ext;

    // Handshake
    assign advance = !r_out_valid || !i_stall;
    assign process = r_in_valid && advance;
    assign o_stall = r_in_valid && !advance;
    assign take_in = i_valid && !o_stall;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_light <= RST_LIGHT_SP;
            r_front_heavy <= RST_HEAVY_SP;
            r_rear_light  <= RST_LIGHT_SP;
            r_rear_heavy  <= RST_HEAVY_SP;
            r_tol         <= RST_TOL;
            r_debounce    <= RST_DEBOUNCE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FRONT_LIGHT: r_front_light <= i_cfg_wdata[SETPOINT_W-1:0];
                CFG_FRONT_HEAVY: r_front_heavy <= i_cfg_wdata[SETPOINT_W-1:0];
                CFG_REAR_LIGHT:  r_rear_light  <= i_cfg_wdata[SETPOINT_W-1:0];
                CFG_REAR_HEAVY:  r_rear_heavy  <= i_cfg_wdata[SETPOINT_W-1:0];
                CFG_TOLERANCE:   r_tol         <= i_cfg_wdata[TOL_W-1:0];
                CFG_DEBOUNCE:    r_debounce    <= i_cfg_wdata[DEB_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (take_in) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_op      <= i_op;
            r_idx     <= i_button_index;
            r_pressed <= i_button_pressed;
            r_time    <= i_time_ms;
            r_psi     <= i_pressure_psi;
        end
    end

    // Debounce unit
    assign evt.en    = process && (r_op == OP_BUTTON);
    assign evt.idx   = r_idx;
    assign evt.level = r_pressed;
    assign evt.stamp = r_time;

    spvc_debounce u_debounce (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_evt         (evt),
        .i_debounce_ms (r_debounce),
        .o_levels      (levels),
        .o_seat        (seat)
    );

    // Pressure compare against the front target
    assign p_ext   = $signed({{(PSI_EXT_W-PSI_W){r_psi[PSI_W-1]}}, r_psi});
    assign sp_ext  = $signed({{(PSI_EXT_W-SETPOINT_W){1'b0}}, r_front});
    assign tol_ext = $signed({{(PSI_EXT_W-TOL_W){1'b0}}, r_tol});

    always_comb begin
        n_drive = r_drive;
        if (p_ext < sp_ext - tol_ext) begin
            n_drive = DRIVE_FILL;
        end else if (p_ext > sp_ext + VENT_MARGIN) begin
            n_drive = DRIVE_VENT;
        end else if ((p_ext >= sp_ext) && (p_ext <= sp_ext + tol_ext)) begin
            n_drive = DRIVE_OFF;
        end
    end

    // Result register and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_drive     <= DRIVE_OFF;
            r_front     <= RST_LIGHT_SP;
            r_rear      <= RST_LIGHT_SP;
        end else begin
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (process && (r_op == OP_PRESSURE)) begin
                r_drive <= n_drive;
            end
            if (seat.latch) begin
                r_front <= seat.heavy ? r_front_heavy : r_front_light;
                r_rear  <= seat.heavy ? r_rear_heavy  : r_rear_light;
            end
        end
    end

    // Outputs
    assign o_valid          = r_out_valid;
    assign o_compressor_on  = r_drive.comp;
    assign o_fill_valve_on  = r_drive.fill;
    assign o_vent_valve_on  = r_drive.vent;
    assign o_front_setpoint = r_front;
    assign o_rear_setpoint  = r_rear;
    assign o_stable_buttons = REPORT_W'(levels);

endmodule

>>> design/spvc_debounce.sv
// Per-button debounce state: stable levels, last accept times, seat latch request.
module spvc_debounce (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  spvc_pkg::t_btn_evt                   i_evt,
    input  logic [spvc_pkg::DEB_W-1:0]           i_debounce_ms,
    output logic [spvc_pkg::BUTTON_COUNT-1:0]    o_levels,
    output spvc_pkg::t_seat_upd                  o_seat
);
    import spvc_pkg::*;

    logic [BUTTON_COUNT-1:0] r_level;
    logic [BUTTON_COUNT-1:0] n_level;
    logic [TIME_W-1:0]       r_last [BUTTON_COUNT];

    logic [BTN_IDX_W-1:0]    slot;
    logic                    in_range;
    logic [TIME_W-1:0]       elapsed;
    logic                    accept;
    logic                    is_seat;
    logic [LEVEL_PAD_W-1:0]  pad;

    // Event qualification
    assign slot     = BTN_IDX_W'(i_evt.idx);
    assign in_range = (int'(i_evt.idx) < BUTTON_COUNT);
    assign elapsed  = i_evt.stamp - r_last[slot];
    assign accept   = i_evt.en && in_range && (i_evt.level != r_level[slot]) &&
                      !(elapsed < TIME_W'(i_debounce_ms));

    // Next levels
    always_comb begin
        n_level = r_level;
        if (accept) begin
            n_level[slot] = i_evt.level;
        end
    end

    // Seat occupancy after the update; missing sensors read as zero
    assign pad     = LEVEL_PAD_W'(n_level);
    assign is_seat = (int'(i_evt.idx) == SEAT_A) || (int'(i_evt.idx) == SEAT_B) ||
                     (int'(i_evt.idx) == SEAT_C);

    assign o_seat.latch = accept && is_seat;
    assign o_seat.heavy = (pad[SEAT_A] & pad[SEAT_B]) | (pad[SEAT_A] & pad[SEAT_C]) |
                          (pad[SEAT_B] & pad[SEAT_C]);

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= '0;
            for (int k = 0; k < BUTTON_COUNT; k++) begin
                r_last[k] <= '0;
            end
        end else begin
            r_level <= n_level;
            if (accept) begin
                r_last[slot] <= i_evt.stamp;
            end
        end
    end

    assign o_levels = r_level;

endmodule

>>> design/spvc_checker.sv
// Port-level checks for the seat pressure valve controller, bound to the top level.
module spvc_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_stall,
    input  logic                                o_valid,
    input  logic                                i_stall,
    input  logic                                o_compressor_on,
    input  logic                                o_fill_valve_on,
    input  logic                                o_vent_valve_on,
    input  logic [7:0]                          o_front_setpoint,
    input  logic [7:0]                          o_rear_setpoint,
    input  logic [7:0]                          o_stable_buttons
);

    // Stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_front_setpoint) &&
            $stable(o_rear_setpoint) && $stable(o_stable_buttons) &&
            $stable(o_compressor_on) && $stable(o_vent_valve_on)))
        else $error("result changed while stalled");

    // Compressor and fill valve always move together
    a_fill_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_compressor_on == o_fill_valve_on)
        else $error("compressor and fill valve disagree");

    // Never fill and vent at once
    a_no_fight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_vent_valve_on && o_compressor_on))
        else $error("vent open while compressor runs");

    // Input stall only when a result is waiting
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with empty output");

    // Reset empties the output
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

endmodule

bind seat_pressure_valve_controller_core spvc_checker u_spvc_checker (.*);
